// ===== sv/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// widths, codes and link types shared by the ready queue and its interfaces
// ----------------------------------------------------------------------------
package mpq_pkg;

    // thread identifiers and link pointers
    localparam int TID_W       = 6;
    localparam int MAX_THREADS = 2 ** TID_W;
    localparam int LINK_W      = TID_W + 1;

    // priority levels
    localparam int LVL_W      = 4;
    localparam int NUM_LEVELS = 11;
    localparam int TOP_LEVEL  = NUM_LEVELS - 1;

    localparam int ACT_W = 2;
    localparam int ST_W  = 3;

    typedef logic [LINK_W-1:0] t_link;

    // null marker: one past the last thread
    localparam t_link NIL = t_link'(MAX_THREADS);

    // request codes
    localparam logic [ACT_W-1:0] ACT_ENQ     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PROMOTE = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_ALREADY   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTQ      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTHIGHER = 3'd4;

endpackage

// ===== sv/mpq_if.sv =====
// ----------------------------------------------------------------------------
// mpq interfaces
// valid/ready channels for requests into and results out of the ready queue
// ----------------------------------------------------------------------------
interface mpq_in_if;
    logic                          valid;
    logic                          ready;
    logic [mpq_pkg::ACT_W-1:0]     action;
    logic [mpq_pkg::TID_W-1:0]     thread_id;
    logic [mpq_pkg::LVL_W-1:0]     level;

    modport source (output valid, output action, output thread_id, output level,
                    input ready);
    modport sink   (input valid, input action, input thread_id, input level,
                    output ready);
endinterface

interface mpq_out_if;
    logic                          valid;
    logic                          ready;
    logic [mpq_pkg::TID_W-1:0]     chosen_thread;
    logic [mpq_pkg::LVL_W-1:0]     chosen_level;
    logic                          found;
    logic [mpq_pkg::ST_W-1:0]      status;

    modport source (output valid, output chosen_thread, output chosen_level,
                    output found, output status, input ready);
    modport sink   (input valid, input chosen_thread, input chosen_level,
                    input found, input status, output ready);
endinterface

// ===== sv/multilevel_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue
// eleven-level ready queue of thread ids: enqueue, dequeue highest, promote
// ----------------------------------------------------------------------------
//  channel  dir  beat carries                               handshake
//  i_req    in   action, thread_id, level                   valid/ready
//  o_res    out  chosen_thread, chosen_level, found, status valid/ready
//
//  one request at a time; the state machine owns the link memories
//  immediate results come from idle; a dequeue passes the read state,
//  an enqueue the first push state and, if the level has a tail, the
//  second, which relinks the old tail; a promote reads, then answers
//  not higher or unlinks and appends as an enqueue; each result then
//  passes the pending stage and output register before reaching o_res
//  reset clears queued flags, head/tail tables and the non-empty mask at
//  once; link memories are not cleared and need no sweep
//  a stalled o_res holds its beat; one further finished result may wait in
//  the pending stage, and i_req stays not ready until that stage empties
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpq_in_if.sink     i_req,
    mpq_out_if.source  o_res
);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_PUSH1 = 4'b0100,
        S_PUSH2 = 4'b1000
    } t_state;

    typedef struct packed {
        logic [mpq_pkg::TID_W-1:0] tid;
        logic [mpq_pkg::LVL_W-1:0] lvl;
        logic                      found;
        logic [mpq_pkg::ST_W-1:0]  status;
    } t_result;

    // link memories: next, prev and level of every thread
    mpq_pkg::t_link            next_mem [mpq_pkg::MAX_THREADS];
    mpq_pkg::t_link            prev_mem [mpq_pkg::MAX_THREADS];
    logic [mpq_pkg::LVL_W-1:0] lvl_mem  [mpq_pkg::MAX_THREADS];

    // registered read data
    mpq_pkg::t_link            r_next_q;
    mpq_pkg::t_link            r_prev_q;
    logic [mpq_pkg::LVL_W-1:0] r_lvl_q;

    // per-level tables, non-empty mask and per-thread queued flags
    mpq_pkg::t_link                r_head [mpq_pkg::NUM_LEVELS];
    mpq_pkg::t_link                r_tail [mpq_pkg::NUM_LEVELS];
    logic [mpq_pkg::NUM_LEVELS-1:0] r_mask;
    logic [mpq_pkg::MAX_THREADS-1:0] r_qflag;

    // sequencer
    t_state                    r_state, n_state;
    logic [mpq_pkg::ACT_W-1:0] r_act,   n_act;
    logic [mpq_pkg::TID_W-1:0] r_tid,   n_tid;
    logic [mpq_pkg::LVL_W-1:0] r_lv,    n_lv;
    mpq_pkg::t_link            r_tl,    n_tl;

    // result stages
    t_result r_pend;
    logic    r_pend_v;
    t_result r_out;
    logic    r_out_v;

    logic    res_load;
    t_result res;

    // write ports
    logic                      next_we,  prev_we,  lvl_we;
    logic [mpq_pkg::TID_W-1:0] next_addr, prev_addr, lvl_addr;
    mpq_pkg::t_link            next_wdata, prev_wdata;
    logic [mpq_pkg::LVL_W-1:0] lvl_wdata;

    logic                      head_we, tail_we, mask_we, flag_we;
    logic [mpq_pkg::LVL_W-1:0] head_idx, tail_idx, mask_idx;
    mpq_pkg::t_link            head_wdata, tail_wdata;
    logic                      mask_val, flag_val;

    // request decode
    logic                      in_fire;
    logic [mpq_pkg::LVL_W-1:0] lv_sat;
    logic [mpq_pkg::LVL_W-1:0] top;
    mpq_pkg::t_link            head_top;
    mpq_pkg::t_link            tail_new;
    logic [mpq_pkg::TID_W-1:0] rd_addr;
    logic                      out_free;

    assign in_fire     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_pend_v;
    assign out_free    = !r_out_v || o_res.ready;

    // levels beyond the top saturate
    assign lv_sat = (i_req.level >= mpq_pkg::LVL_W'(mpq_pkg::NUM_LEVELS))
                  ? mpq_pkg::LVL_W'(mpq_pkg::TOP_LEVEL) : i_req.level;

    // highest non-empty level
    always_comb begin
        top = '0;
        for (int i = 0; i < mpq_pkg::NUM_LEVELS; i++) begin
            if (r_mask[i]) begin
                top = mpq_pkg::LVL_W'(i);
            end
        end
    end

    assign head_top = r_head[top];
    assign tail_new = r_tail[r_lv];

    // dequeue reads the head entry, promote reads the thread's own entry
    assign rd_addr = (i_req.action == mpq_pkg::ACT_DEQ) ? head_top[mpq_pkg::TID_W-1:0]
                                                        : i_req.thread_id;

    // ------------------------------------------------------------------------
    // sequencer: decide, unlink, append
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_tid   = r_tid;
        n_lv    = r_lv;
        n_tl    = r_tl;

        res_load = 1'b0;
        res      = '{tid: '0, lvl: '0, found: 1'b0, status: mpq_pkg::ST_OK};

        next_we    = 1'b0;
        next_addr  = r_tid;
        next_wdata = mpq_pkg::NIL;
        prev_we    = 1'b0;
        prev_addr  = r_tid;
        prev_wdata = mpq_pkg::NIL;
        lvl_we     = 1'b0;
        lvl_addr   = r_tid;
        lvl_wdata  = r_lv;

        head_we    = 1'b0;
        head_idx   = r_lv;
        head_wdata = mpq_pkg::NIL;
        tail_we    = 1'b0;
        tail_idx   = r_lv;
        tail_wdata = mpq_pkg::NIL;
        mask_we    = 1'b0;
        mask_idx   = r_lv;
        mask_val   = 1'b0;
        flag_we    = 1'b0;
        flag_val   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_act = i_req.action;
                    n_tid = i_req.thread_id;
                    n_lv  = lv_sat;
                    unique case (i_req.action)
                        mpq_pkg::ACT_ENQ: begin
                            if (r_qflag[i_req.thread_id]) begin
                                res_load   = 1'b1;
                                res.status = mpq_pkg::ST_ALREADY;
                            end else begin
                                n_state = S_PUSH1;
                            end
                        end
                        mpq_pkg::ACT_DEQ: begin
                            if (r_mask == '0 || head_top == mpq_pkg::NIL) begin
                                res_load   = 1'b1;
                                res.status = mpq_pkg::ST_EMPTY;
                            end else begin
                                n_tid   = head_top[mpq_pkg::TID_W-1:0];
                                n_lv    = top;
                                n_state = S_RD;
                            end
                        end
                        mpq_pkg::ACT_PROMOTE: begin
                            if (!r_qflag[i_req.thread_id]) begin
                                res_load   = 1'b1;
                                res.status = mpq_pkg::ST_NOTQ;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            // unused code: plain ok beat
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            S_RD: begin
                if (r_act == mpq_pkg::ACT_PROMOTE && r_lv <= r_lvl_q) begin
                    res_load   = 1'b1;
                    res.status = mpq_pkg::ST_NOTHIGHER;
                    n_state    = S_IDLE;
                end else begin
                    // unlink from the old level
                    if (r_prev_q == mpq_pkg::NIL) begin
                        head_we    = 1'b1;
                        head_idx   = r_lvl_q;
                        head_wdata = r_next_q;
                    end else begin
                        next_we    = 1'b1;
                        next_addr  = r_prev_q[mpq_pkg::TID_W-1:0];
                        next_wdata = r_next_q;
                    end
                    if (r_next_q == mpq_pkg::NIL) begin
                        tail_we    = 1'b1;
                        tail_idx   = r_lvl_q;
                        tail_wdata = r_prev_q;
                    end else begin
                        prev_we    = 1'b1;
                        prev_addr  = r_next_q[mpq_pkg::TID_W-1:0];
                        prev_wdata = r_prev_q;
                    end
                    // last thread of the level gone
                    if (r_prev_q == mpq_pkg::NIL && r_next_q == mpq_pkg::NIL) begin
                        mask_we  = 1'b1;
                        mask_idx = r_lvl_q;
                        mask_val = 1'b0;
                    end
                    flag_we  = 1'b1;
                    flag_val = 1'b0;
                    if (r_act == mpq_pkg::ACT_DEQ) begin
                        res_load  = 1'b1;
                        res.tid   = r_tid;
                        res.lvl   = r_lv;
                        res.found = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_PUSH1;
                    end
                end
            end

            S_PUSH1: begin
                // append at the tail of the new level
                next_we    = 1'b1;
                next_wdata = mpq_pkg::NIL;
                prev_we    = 1'b1;
                prev_wdata = tail_new;
                lvl_we     = 1'b1;
                if (tail_new == mpq_pkg::NIL) begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, r_tid};
                end
                tail_we    = 1'b1;
                tail_wdata = {1'b0, r_tid};
                mask_we    = 1'b1;
                mask_val   = 1'b1;
                flag_we    = 1'b1;
                flag_val   = 1'b1;
                n_tl       = tail_new;
                if (tail_new == mpq_pkg::NIL) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_PUSH2;
                end
            end

            S_PUSH2: begin
                // old tail now points at the new thread
                next_we    = 1'b1;
                next_addr  = r_tl[mpq_pkg::TID_W-1:0];
                next_wdata = {1'b0, r_tid};
                res_load   = 1'b1;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // link memories, read only when a request is taken
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_addr] <= next_wdata;
        end
        if (in_fire) begin
            r_next_q <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_addr] <= prev_wdata;
        end
        if (in_fire) begin
            r_prev_q <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_addr] <= lvl_wdata;
        end
        if (in_fire) begin
            r_lvl_q <= lvl_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // tables, flags and control
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mpq_pkg::NUM_LEVELS; i++) begin
                r_head[i] <= mpq_pkg::NIL;
                r_tail[i] <= mpq_pkg::NIL;
            end
            r_mask   <= '0;
            r_qflag  <= '0;
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (head_we) begin
                r_head[head_idx] <= head_wdata;
            end
            if (tail_we) begin
                r_tail[tail_idx] <= tail_wdata;
            end
            if (mask_we) begin
                r_mask[mask_idx] <= mask_val;
            end
            if (flag_we) begin
                r_qflag[r_tid] <= flag_val;
            end
            r_state <= n_state;

            // pending stage feeds the output register
            if (res_load) begin
                r_pend_v <= 1'b1;
            end else if (r_pend_v && out_free) begin
                r_pend_v <= 1'b0;
            end
            if (r_pend_v && out_free) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_tid <= n_tid;
        r_lv  <= n_lv;
        r_tl  <= n_tl;
        if (res_load) begin
            r_pend <= res;
        end
        if (r_pend_v && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.chosen_thread = r_out.tid;
    assign o_res.chosen_level  = r_out.lvl;
    assign o_res.found         = r_out.found;
    assign o_res.status        = r_out.status;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    logic [mpq_pkg::NUM_LEVELS-1:0] head_live;

    always_comb begin
        for (int i = 0; i < mpq_pkg::NUM_LEVELS; i++) begin
            head_live[i] = (r_head[i] != mpq_pkg::NIL);
        end
    end

    // non-empty mask tracks the head table
    a_mask_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask == head_live)
        else $error("non-empty mask out of step with head table");

    // a dequeued head sits at the level it was found on
    a_deq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_act == mpq_pkg::ACT_DEQ) |-> r_lvl_q == r_lv)
        else $error("dequeued thread level mismatch");

    // relink of the old tail only when one existed
    a_push2_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH2) |-> r_tl != mpq_pkg::NIL)
        else $error("old tail relink without a tail");

    // a taken request either keeps the sequencer busy or leaves a result
    a_fire_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE) || r_pend_v)
        else $error("request taken without progress");

    // a pending result moves on as soon as the output slot frees
    a_pend_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && out_free) |=> r_out_v)
        else $error("pending result not forwarded");

endmodule
